[design/mlqs_pkg.sv]
// Shared types and constants for the multilevel queue scheduler.
package mlqs_pkg;

   localparam int NUM_LEVELS = 8;
   localparam int LEVEL_W    = 3;
   localparam int CLASS_W    = 2;
   localparam int THREAD_W   = 10;
   localparam int SLICE_W    = 8;
   localparam int TOTAL_W    = 10;
   localparam int CSR_IDX_W  = 4;

   // Reset values of the per-level time slice registers
   localparam logic [SLICE_W-1:0] SLICE_RESET [NUM_LEVELS] =
      '{8'd3, 8'd3, 8'd3, 8'd3, 8'd5, 8'd6, 8'd7, 8'd8};

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              command;
      logic [THREAD_W-1:0]  thread_id;
      logic [CLASS_W-1:0]   process_class;
      logic                 was_preempted;
   } req_payload_type;

   typedef struct packed {
      logic                 found;
      logic [THREAD_W-1:0]  chosen_thread;
      logic [LEVEL_W-1:0]   chosen_level;
      logic [SLICE_W-1:0]   slice_length;
      logic                 overflow;
      logic [TOTAL_W-1:0]   total_waiting;
   } rsp_payload_type;

   // Per-transfer decision from the level controller to the store and output stage
   typedef struct packed {
      logic                 write_en;
      logic                 read_en;
      logic                 found;
      logic                 overflow;
      logic [LEVEL_W-1:0]   level;
   } ctl_type;

endpackage

[design/mlqs_chan_if.sv]
// Valid/ready channel interface carrying one payload struct.
interface mlqs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/multilevel_queue_scheduler.sv]
// Top level of the multilevel queue scheduler.
//
//   channel  | dir | handshake        | contents
//   ---------+-----+------------------+-------------------------------------------
//   req_chan | in  | valid/ready      | command, thread_id, process_class, preempt
//   rsp_chan | out | valid/ready      | found, thread, level, slice, overflow, total
//   csr_*    | in  | write enable     | slice_level0..7 at index 0..7
//
// One transfer per cycle while the result is not stalled; each result appears
// in the cycle after its request. Pointers and counts update at the request
// transfer; the store is read into a data register on dequeue.
// A stalled result holds the output register and blocks new requests.
// Reset clears pointers, counts and total, and loads the slice registers with their reset values.
module multilevel_queue_scheduler #(
   parameter int QUEUE_DEPTH    = 64,
   parameter int THREAD_ID_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   mlqs_chan_if.sink                      req_chan,
   mlqs_chan_if.source                    rsp_chan,
   input  logic                           csr_we,
   input  logic [mlqs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlqs_pkg::SLICE_W-1:0]   csr_wdata
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TOT_W  = $clog2(mlqs_pkg::NUM_LEVELS * QUEUE_DEPTH + 1);
   localparam int ADDR_W = mlqs_pkg::LEVEL_W + PTR_W;
   localparam int DATA_W = (THREAD_ID_BITS < mlqs_pkg::THREAD_W) ?
                           THREAD_ID_BITS : mlqs_pkg::THREAD_W;

   mlqs_pkg::req_payload_type req;
   mlqs_pkg::ctl_type         ctl;
   logic                      accept;
   logic [mlqs_pkg::LEVEL_W-1:0] enq_level;
   logic [PTR_W-1:0]          ptr;
   logic [TOT_W-1:0]          total;
   logic [DATA_W-1:0]         rdata;
   logic [TOT_W+mlqs_pkg::TOTAL_W-1:0]    total_wide;
   logic [DATA_W+mlqs_pkg::THREAD_W-1:0]  thread_wide;

   logic [mlqs_pkg::SLICE_W-1:0] slice_ff [mlqs_pkg::NUM_LEVELS];
   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic                         overflow_ff;
   logic [mlqs_pkg::LEVEL_W-1:0] level_ff;
   logic [mlqs_pkg::SLICE_W-1:0] slice_out_ff;

   assign req       = req_chan.payload;
   assign enq_level = {req.was_preempted, req.process_class};

   // Accept whenever the output register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   mlqs_level_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W),
      .CNT_W       (CNT_W),
      .TOT_W       (TOT_W)
   ) u_level_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req.command),
      .enq_level (enq_level),
      .ctl       (ctl),
      .ptr       (ptr),
      .total     (total)
   );

   mlqs_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock    (clock),
      .write_en (ctl.write_en),
      .read_en  (ctl.read_en),
      .addr     ({ctl.level, ptr}),
      .wdata    (req.thread_id[DATA_W-1:0]),
      .rdata    (rdata)
   );

   // Slice registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlqs_pkg::NUM_LEVELS; i++) begin
            slice_ff[i] <= mlqs_pkg::SLICE_RESET[i];
         end
      end else if (csr_we &&
                   (csr_index < mlqs_pkg::CSR_IDX_W'(mlqs_pkg::NUM_LEVELS))) begin
         slice_ff[csr_index[mlqs_pkg::LEVEL_W-1:0]] <= csr_wdata;
      end
   end

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output payload, loaded with each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff     <= ctl.found;
         overflow_ff  <= ctl.overflow;
         level_ff     <= ctl.found ? ctl.level : '0;
         slice_out_ff <= ctl.found ? slice_ff[ctl.level] : '0;
      end
   end

   assign total_wide  = {{mlqs_pkg::TOTAL_W{1'b0}}, total};
   assign thread_wide = {{mlqs_pkg::THREAD_W{1'b0}}, rdata};

   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.payload.found         = found_ff;
   assign rsp_chan.payload.chosen_thread =
      found_ff ? thread_wide[mlqs_pkg::THREAD_W-1:0] : '0;
   assign rsp_chan.payload.chosen_level  = level_ff;
   assign rsp_chan.payload.slice_length  = slice_out_ff;
   assign rsp_chan.payload.overflow      = overflow_ff;
   assign rsp_chan.payload.total_waiting = total_wide[mlqs_pkg::TOTAL_W-1:0];

endmodule

[design/mlqs_level_ctrl.sv]
// Per-level head/tail pointers, fill counts, level selection and running total.
module mlqs_level_ctrl #(
   parameter int QUEUE_DEPTH = 64,
   parameter int PTR_W       = 6,
   parameter int CNT_W       = 7,
   parameter int TOT_W       = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  mlqs_pkg::cmd_type             command,
   input  logic [mlqs_pkg::LEVEL_W-1:0]  enq_level,
   output mlqs_pkg::ctl_type             ctl,
   output logic [PTR_W-1:0]              ptr,
   output logic [TOT_W-1:0]              total
);

   logic [PTR_W-1:0] head_ff [mlqs_pkg::NUM_LEVELS];
   logic [PTR_W-1:0] tail_ff [mlqs_pkg::NUM_LEVELS];
   logic [CNT_W-1:0] count_ff [mlqs_pkg::NUM_LEVELS];
   logic [TOT_W-1:0] total_ff;

   logic [mlqs_pkg::NUM_LEVELS-1:0] nonempty;
   logic                            any_waiting;
   logic [mlqs_pkg::LEVEL_W-1:0]    deq_level;
   logic                            enq_full;
   logic                            is_deq;
   logic [PTR_W-1:0]                head_sel;
   logic [PTR_W-1:0]                tail_sel;
   logic [PTR_W-1:0]                ptr_next;

   // Lowest-numbered non-empty level wins
   always_comb begin
      deq_level = '0;
      for (int i = mlqs_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
         nonempty[i] = (count_ff[i] != '0);
         if (count_ff[i] != '0) begin
            deq_level = mlqs_pkg::LEVEL_W'(i);
         end
      end
      any_waiting = |nonempty;
   end

   assign is_deq   = (command == mlqs_pkg::CMD_DEQUEUE);
   assign enq_full = (count_ff[enq_level] >= CNT_W'(QUEUE_DEPTH));
   assign head_sel = head_ff[deq_level];
   assign tail_sel = tail_ff[enq_level];

   // Decision for this transfer
   always_comb begin
      ctl.found    = is_deq && any_waiting;
      ctl.overflow = !is_deq && enq_full;
      ctl.level    = is_deq ? deq_level : enq_level;
      ctl.write_en = accept && !is_deq && !enq_full;
      ctl.read_en  = accept && is_deq && any_waiting;
      ptr          = is_deq ? head_sel : tail_sel;
   end

   // Wrap the selected pointer at the queue depth
   assign ptr_next = ({1'b0, ptr} + 1'b1 >= (PTR_W + 1)'(QUEUE_DEPTH)) ? '0 : ptr + 1'b1;

   // Pointer, count and total updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlqs_pkg::NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (ctl.write_en) begin
         tail_ff[enq_level]  <= ptr_next;
         count_ff[enq_level] <= count_ff[enq_level] + 1'b1;
         total_ff            <= total_ff + 1'b1;
      end else if (ctl.read_en) begin
         head_ff[deq_level]  <= ptr_next;
         count_ff[deq_level] <= count_ff[deq_level] - 1'b1;
         total_ff            <= total_ff - 1'b1;
      end
   end

   assign total = total_ff;

endmodule

[design/mlqs_store.sv]
// Thread identifier store: one write port, one registered read port.
module mlqs_store #(
   parameter int ADDR_W = 9,
   parameter int DATA_W = 10
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // Write on enqueue
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= wdata;
      end
   end

   // Read on dequeue; held until the next dequeue
   always_ff @(posedge clock) begin
      if (read_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/mlqs_checker.sv]
// Port-level checks on the multilevel queue scheduler, bound to the top level.
module mlqs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          found,
   input logic [mlqs_pkg::THREAD_W-1:0] chosen_thread,
   input logic [mlqs_pkg::LEVEL_W-1:0]  chosen_level,
   input logic [mlqs_pkg::SLICE_W-1:0]  slice_length,
   input logic                          overflow
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Free output register always takes a request
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // A stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Empty answer carries zero thread, level and slice
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |->
         chosen_thread == '0 && chosen_level == '0 && slice_length == '0)
      else $error("nonzero fields without a found thread");

   // Overflow and found never coincide
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(found && overflow))
      else $error("found and overflow both set");

endmodule

bind multilevel_queue_scheduler mlqs_checker u_mlqs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .found         (rsp_chan.payload.found),
   .chosen_thread (rsp_chan.payload.chosen_thread),
   .chosen_level  (rsp_chan.payload.chosen_level),
   .slice_length  (rsp_chan.payload.slice_length),
   .overflow      (rsp_chan.payload.overflow)
);
